@@ rtl/core/spt_pkg.sv @@
// Shared types and constants for the stride prefetch table.
package spt_pkg;

  localparam int unsigned SETS_DEF = 16;
  localparam int unsigned WAYS_DEF = 4;
  localparam int unsigned XLEN     = 64;
  localparam int unsigned BOB_W    = 4;

  localparam logic [BOB_W-1:0] BOB_RESET = 4'd6;

  localparam logic [1:0] CONF_MAX   = 2'd3;
  localparam logic [1:0] CONF_PF    = 2'd2;
  localparam logic [1:0] CONF_ADOPT = 2'd1;
  localparam logic [1:0] CONF_NEW   = 2'd0;

  typedef struct packed {
    logic            valid;
    logic [XLEN-1:0] pc;
    logic [XLEN-1:0] prev_line;
    logic [XLEN-1:0] stride;
    logic [1:0]      conf;
  } spt_entry_t;

  localparam int unsigned ENT_W = $bits(spt_entry_t);

  // controller -> datapath commands
  typedef struct packed {
    logic load;     // input beat taken, start row read
    logic capture;  // row data back, pick way
    logic commit;   // write row back, load result register
    logic clear;    // post-reset sweep writes a reset row
  } spt_cmd_t;

endpackage

@@ rtl/core/spt_if.sv @@
// Handshake channel interfaces for the access and result streams.
interface spt_in_if;
  import spt_pkg::*;
  logic            valid;
  logic            ready;
  logic [XLEN-1:0] access_pc;
  logic [XLEN-1:0] access_address;

  modport source (output valid, output access_pc, output access_address, input ready);
  modport sink (input valid, input access_pc, input access_address, output ready);
endinterface

interface spt_out_if;
  import spt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   entry_was_present;
  logic signed [XLEN-1:0] current_stride;
  logic [1:0]             current_confidence;
  logic                   prefetch_ok;

  modport source (output valid, output entry_was_present, output current_stride,
                  output current_confidence, output prefetch_ok, input ready);
  modport sink (input valid, input entry_was_present, input current_stride,
                input current_confidence, input prefetch_ok, output ready);
endinterface

@@ rtl/core/spt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module spt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/spt_ctrl.sv @@
// Sequencing controller: clear sweep, read, update and result handshake.
module spt_ctrl #(
  parameter int unsigned SETS = spt_pkg::SETS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output spt_pkg::spt_cmd_t                        cmd,
  output logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] clr_idx
);
  import spt_pkg::*;

  localparam int unsigned SET_W = SETS > 1 ? $clog2(SETS) : 1;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_UPD} state_t;

  state_t           state_r, state_nxt;
  logic [SET_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (clr_cnt_r == SET_W'(SETS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.capture = 1'b1;
        state_nxt   = S_UPD;
      end
      S_UPD: begin
        // hold the update until the result register has room
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign clr_idx   = clr_cnt_r;

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_upd_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && out_valid_r && !out_ready) |=> (state_r == S_UPD))
    else $error("update left while result register full");
`endif

endmodule

@@ rtl/core/spt_dpath.sv @@
// Datapath: row RAM, way match, victim pick, stride/confidence update, result register.
module spt_dpath #(
  parameter int unsigned SETS = spt_pkg::SETS_DEF,
  parameter int unsigned WAYS = spt_pkg::WAYS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  spt_pkg::spt_cmd_t                        cmd,
  input  logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] clr_idx,
  input  logic                                     cfg_we,
  input  logic [spt_pkg::BOB_W-1:0]                cfg_wdata,
  input  logic [spt_pkg::XLEN-1:0]                 in_pc,
  input  logic [spt_pkg::XLEN-1:0]                 in_addr,
  output logic                                     res_present,
  output logic signed [spt_pkg::XLEN-1:0]          res_stride,
  output logic [1:0]                               res_conf,
  output logic                                     res_pf
);
  import spt_pkg::*;

  localparam int unsigned SET_W  = SETS > 1 ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W  = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int unsigned AGE_W  = WAY_W;
  localparam int unsigned SLOT_W = ENT_W + AGE_W;
  localparam int unsigned ROW_W  = WAYS * SLOT_W;

  // block offset register
  logic [BOB_W-1:0] bob_r;

  // per-item registers
  logic [SET_W-1:0] set_r;
  logic [XLEN-1:0]  pc_r;
  logic [XLEN-1:0]  line_r;
  logic [BOB_W-1:0] b_r;
  logic             hit_r;
  logic [WAY_W-1:0] way_r;
  spt_entry_t       ent_r;
  logic [XLEN-1:0]  q_r;
  logic [ROW_W-1:0] row_r;
  logic [WAYS-1:0]  valids_r;
  logic [AGE_W-1:0] ages_r [WAYS];

  // result register
  logic                   present_r;
  logic signed [XLEN-1:0] stride_r;
  logic [1:0]             conf_r;
  logic                   pf_r;

  // RAM hookup
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [SET_W-1:0] ram_raddr;
  logic [ROW_W-1:0] ram_rdata;

  // capture-cycle logic
  spt_entry_t       rd_ent [WAYS];
  logic [AGE_W-1:0] rd_age [WAYS];
  logic [WAYS-1:0]  hit_vec;
  logic             hit_any;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] vic_way;
  logic [WAY_W-1:0] sel_way;
  spt_entry_t       sel_ent;
  logic [XLEN-1:0]  sel_mag;
  logic [XLEN-1:0]  sel_shr;
  logic [XLEN-1:0]  q_nxt;

  // update-cycle logic
  logic [XLEN-1:0]  pred_line;
  logic             correct;
  logic [XLEN-1:0]  new_stride;
  spt_entry_t       upd_ent;
  logic [AGE_W-1:0] upd_age [WAYS];
  logic [ROW_W-1:0] upd_row;
  logic [ROW_W-1:0] clr_row;

  assign ram_raddr = SET_W'(in_pc[2 +: SET_W] & SET_W'(SETS - 1));

  spt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.load),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // way match and victim selection on the returned row
  always_comb begin
    logic             got_inv;
    logic             have_best;
    logic [AGE_W-1:0] best_age;
    got_inv   = 1'b0;
    have_best = 1'b0;
    best_age  = '0;
    hit_any   = 1'b0;
    hit_way   = '0;
    vic_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      rd_ent[w]  = spt_entry_t'(ram_rdata[w*SLOT_W + AGE_W +: ENT_W]);
      rd_age[w]  = ram_rdata[w*SLOT_W +: AGE_W];
      hit_vec[w] = rd_ent[w].valid && (rd_ent[w].pc == pc_r);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    // first invalid way, else oldest with lowest way winning ties
    for (int w = 0; w < WAYS; w++) begin
      if (!got_inv) begin
        if (!rd_ent[w].valid) begin
          got_inv = 1'b1;
          vic_way = WAY_W'(w);
        end else if (!have_best || rd_age[w] > best_age) begin
          have_best = 1'b1;
          best_age  = rd_age[w];
          vic_way   = WAY_W'(w);
        end
      end
    end
    sel_way = hit_any ? hit_way : vic_way;
    sel_ent = rd_ent[sel_way];
    // stride / block size, truncating toward zero
    sel_mag = sel_ent.stride[XLEN-1] ? (XLEN'(0) - sel_ent.stride) : sel_ent.stride;
    sel_shr = sel_mag >> b_r;
    q_nxt   = sel_ent.stride[XLEN-1] ? (XLEN'(0) - sel_shr) : sel_shr;
  end

  // entry and age update
  always_comb begin
    logic [AGE_W-1:0] old_age;
    pred_line  = ent_r.prev_line + q_r;
    correct    = (ent_r.stride != '0) && (pred_line == line_r);
    new_stride = (line_r - ent_r.prev_line) << b_r;
    upd_ent    = ent_r;
    if (!hit_r) begin
      upd_ent.valid     = 1'b1;
      upd_ent.pc        = pc_r;
      upd_ent.prev_line = line_r;
      upd_ent.stride    = XLEN'(1) << b_r;
      upd_ent.conf      = CONF_NEW;
    end else begin
      if (correct) begin
        if (ent_r.conf != CONF_MAX) begin
          upd_ent.conf = ent_r.conf + 2'd1;
        end
      end else if (ent_r.conf == CONF_MAX) begin
        upd_ent.conf = ent_r.conf - 2'd1;
      end else begin
        upd_ent.stride = new_stride;
        upd_ent.conf   = CONF_ADOPT;
      end
      upd_ent.prev_line = line_r;
    end

    old_age = ages_r[way_r];
    upd_row = row_r;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == way_r) begin
        upd_age[w] = '0;
      end else if (valids_r[w] && ages_r[w] < old_age) begin
        upd_age[w] = ages_r[w] + 1'b1;
      end else begin
        upd_age[w] = ages_r[w];
      end
      upd_row[w*SLOT_W +: AGE_W] = upd_age[w];
      if (WAY_W'(w) == way_r) begin
        upd_row[w*SLOT_W + AGE_W +: ENT_W] = upd_ent;
      end
    end
  end

  // reset row: all invalid, age equal to way number
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      clr_row[w*SLOT_W +: SLOT_W] = {ENT_W'(0), AGE_W'(w)};
    end
  end

  always_comb begin
    ram_we    = cmd.commit || cmd.clear;
    ram_waddr = cmd.commit ? set_r : clr_idx;
    ram_wdata = cmd.commit ? upd_row : clr_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bob_r <= BOB_RESET;
    end else if (cfg_we) begin
      bob_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_r  <= ram_raddr;
      pc_r   <= in_pc;
      line_r <= in_addr >> bob_r;
      b_r    <= bob_r;
    end
    if (cmd.capture) begin
      hit_r <= hit_any;
      way_r <= sel_way;
      ent_r <= sel_ent;
      q_r   <= q_nxt;
      row_r <= ram_rdata;
      for (int w = 0; w < WAYS; w++) begin
        valids_r[w] <= rd_ent[w].valid;
        ages_r[w]   <= rd_age[w];
      end
    end
    if (cmd.commit) begin
      present_r <= hit_r;
      stride_r  <= upd_ent.stride;
      conf_r    <= upd_ent.conf;
      pf_r      <= (upd_ent.conf >= CONF_PF);
    end
  end

  assign res_present = present_r;
  assign res_stride  = stride_r;
  assign res_conf    = conf_r;
  assign res_pf      = pf_r;

`ifndef ASSERT_OFF
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> $onehot0(hit_vec))
    else $error("pc present in more than one way of a set");
`endif

endmodule

@@ rtl/core/stride_prefetch_table_unit.sv @@
// Top level: PC-indexed set-associative stride table with handshake channels.
// One access in flight at a time: accept, row read, row write on the single row RAM.
// A result waiting in the output register does not block the next input beat.
// Reset (rst_n, synchronous): a clearing pass writes each of the SETS rows
// with in ready low; the block offset register resets to 6.
module stride_prefetch_table_unit #(
  parameter int unsigned SETS = spt_pkg::SETS_DEF,
  parameter int unsigned WAYS = spt_pkg::WAYS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  spt_in_if.sink                    in_beat,
  spt_out_if.source                 out_beat,
  input  logic                      cfg_we,
  input  logic [spt_pkg::BOB_W-1:0] cfg_wdata
);
  import spt_pkg::*;

  localparam int unsigned SET_W = SETS > 1 ? $clog2(SETS) : 1;

  spt_cmd_t         cmd;
  logic [SET_W-1:0] clr_idx;

  spt_ctrl #(
    .SETS (SETS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_beat.valid),
    .in_ready  (in_beat.ready),
    .out_valid (out_beat.valid),
    .out_ready (out_beat.ready),
    .cmd       (cmd),
    .clr_idx   (clr_idx)
  );

  spt_dpath #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .clr_idx     (clr_idx),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_pc       (in_beat.access_pc),
    .in_addr     (in_beat.access_address),
    .res_present (out_beat.entry_was_present),
    .res_stride  (out_beat.current_stride),
    .res_conf    (out_beat.current_confidence),
    .res_pf      (out_beat.prefetch_ok)
  );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the stride prefetch table: predicts every result beat and compares it.
module testbench;
  import spt_pkg::*;

  localparam int N_SETS = SETS_DEF;
  localparam int N_WAYS = WAYS_DEF;
  localparam int N_ENT = N_SETS * N_WAYS;
  localparam int POOL = 20;
  localparam int PHASE_ITEMS = 230;
  localparam int GAP_PCT = 12;
  localparam int N_PHASES = 8;
  localparam logic [BOB_W-1:0] PHASE_SHIFT [N_PHASES] =
    '{BOB_RESET, 4'd0, 4'd15, 4'd12, 4'd13, 4'd1, 4'd9, 4'd4};

  typedef struct packed {
    logic [XLEN-1:0] pc;
    logic [XLEN-1:0] addr;
  } access_t;

  typedef struct packed {
    logic            present;
    logic [XLEN-1:0] stride;
    logic [1:0]      conf;
    logic            pf;
  } entry_view_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [BOB_W-1:0] cfg_wdata = BOB_RESET;

  logic            drv_valid = 1'b0;
  logic [XLEN-1:0] drv_pc = '0;
  logic [XLEN-1:0] drv_addr = '0;
  logic            sink_ready = 1'b0;

  spt_in_if  in_bus ();
  spt_out_if out_bus ();

  assign in_bus.valid = drv_valid;
  assign in_bus.access_pc = drv_pc;
  assign in_bus.access_address = drv_addr;
  assign out_bus.ready = sink_ready;

  stride_prefetch_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_bus),
    .out_beat  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predicted table contents
  logic            tbl_valid  [N_ENT];
  logic [XLEN-1:0] tbl_pc     [N_ENT];
  logic [XLEN-1:0] tbl_line   [N_ENT];
  logic [XLEN-1:0] tbl_stride [N_ENT];
  logic [1:0]      tbl_conf   [N_ENT];
  int              tbl_age    [N_ENT];
  logic [BOB_W-1:0] blk_shift = BOB_RESET;

  access_t     pending_accesses [$];
  entry_view_t expected_results [$];

  int mismatch_count = 0;
  int results_seen = 0;
  int hold_left = 0;
  int hold_mark = 400;
  bit in_took = 1'b0;
  bit no_gaps = 1'b0;

  // access streams with a running address and byte step each
  logic [XLEN-1:0] stream_pc   [POOL];
  logic [XLEN-1:0] stream_addr [POOL];
  logic [XLEN-1:0] stream_step [POOL];

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [XLEN-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [XLEN-1:0] pc_in_set(int set);
    logic [XLEN-1:0] pc;
    pc = rand64();
    return (pc & ~(64'(N_SETS - 1) << 2)) | (64'(set) << 2);
  endfunction

  function automatic logic [XLEN-1:0] pick_step();
    int c;
    int kk;
    logic signed [XLEN-1:0] k;
    c = $urandom_range(99);
    kk = int'($urandom_range(12)) - 6;
    k = 64'(kk);
    if (c < 70) return k << blk_shift;
    if (c < 85) return rand64();
    if (c < 92) return '0;
    return rand64() << blk_shift;
  endfunction

  function automatic entry_view_t predict_access(logic [XLEN-1:0] pc, logic [XLEN-1:0] addr);
    logic [XLEN-1:0] line, new_stride, step, mag;
    int base, way, e, oldest, age_was;
    bit hit, correct, free_found;
    entry_view_t r;
    line = addr >> blk_shift;
    base = int'((pc >> 2) & 64'(N_SETS - 1)) * N_WAYS;
    hit = 1'b0;
    e = base;
    for (way = 0; way < N_WAYS; way++) begin
      if (!hit && tbl_valid[base + way] && tbl_pc[base + way] == pc) begin
        hit = 1'b1;
        e = base + way;
      end
    end
    if (!hit) begin
      // first free way, else the oldest one; lowest way wins a tie
      free_found = 1'b0;
      oldest = -1;
      for (way = 0; way < N_WAYS; way++) begin
        if (!free_found) begin
          if (!tbl_valid[base + way]) begin
            free_found = 1'b1;
            e = base + way;
          end else if (tbl_age[base + way] > oldest) begin
            oldest = tbl_age[base + way];
            e = base + way;
          end
        end
      end
      tbl_valid[e] = 1'b1;
      tbl_pc[e] = pc;
      tbl_line[e] = line;
      tbl_stride[e] = 64'd1 << blk_shift;
      tbl_conf[e] = CONF_NEW;
    end else begin
      new_stride = (line - tbl_line[e]) << blk_shift;
      correct = 1'b0;
      // zero stride never predicts
      if (tbl_stride[e] != '0) begin
        if (tbl_stride[e][XLEN-1]) begin
          mag = (64'd0 - tbl_stride[e]) >> blk_shift;
          step = 64'd0 - mag;
        end else begin
          step = tbl_stride[e] >> blk_shift;
        end
        correct = ((tbl_line[e] + step) == line);
      end
      if (correct) begin
        if (tbl_conf[e] != CONF_MAX) tbl_conf[e] = tbl_conf[e] + 2'd1;
      end else if (tbl_conf[e] == CONF_MAX) begin
        tbl_conf[e] = tbl_conf[e] - 2'd1;
      end else begin
        tbl_stride[e] = new_stride;
        tbl_conf[e] = CONF_ADOPT;
      end
      tbl_line[e] = line;
    end
    age_was = tbl_age[e];
    for (way = 0; way < N_WAYS; way++) begin
      if (base + way != e && tbl_valid[base + way] && tbl_age[base + way] < age_was)
        tbl_age[base + way]++;
    end
    tbl_age[e] = 0;
    r.present = hit;
    r.stride = tbl_stride[e];
    r.conf = tbl_conf[e];
    r.pf = (tbl_conf[e] >= CONF_PF);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [XLEN-1:0] got, logic [XLEN-1:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
  endtask

  task automatic queue_access(logic [XLEN-1:0] pc, logic [XLEN-1:0] addr);
    access_t a;
    a.pc = pc;
    a.addr = addr;
    pending_accesses.push_back(a);
  endtask

  // mostly strided streams, some broken sequences, some stray pcs
  task automatic add_stream_items(int count);
    int c, i;
    repeat (count) begin
      c = $urandom_range(99);
      i = $urandom_range(POOL - 1);
      if (c < 78) begin
        if ($urandom_range(99) < 6) stream_step[i] = pick_step();
        if ($urandom_range(99) < 2) stream_pc[i] = pc_in_set(i % 5);
        stream_addr[i] = stream_addr[i] + stream_step[i];
        queue_access(stream_pc[i], stream_addr[i]);
      end else if (c < 88) begin
        stream_addr[i] = rand64();
        queue_access(stream_pc[i], stream_addr[i]);
      end else begin
        queue_access(rand64(), rand64());
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_accesses.size() != 0 || drv_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // sender
  always @(negedge clk) begin : drive_access
    access_t nxt;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_took) begin
      if (pending_accesses.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
        nxt = pending_accesses.pop_front();
        drv_valid <= 1'b1;
        drv_pc <= nxt.pc;
        drv_addr <= nxt.addr;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off now and then
  always @(negedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else if (hold_left != 0) begin
      sink_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (results_seen >= hold_mark) begin
      sink_ready <= 1'b0;
      hold_left <= 150;
      hold_mark <= hold_mark + 700;
    end else begin
      sink_ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    entry_view_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", out_bus.current_stride, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_bus.entry_was_present !== want.present)
          report_mismatch("entry_was_present", 64'(out_bus.entry_was_present),
                          64'(want.present));
        if (out_bus.current_stride !== want.stride)
          report_mismatch("current_stride", out_bus.current_stride, want.stride);
        if (out_bus.current_confidence !== want.conf)
          report_mismatch("current_confidence", 64'(out_bus.current_confidence),
                          64'(want.conf));
        if (out_bus.prefetch_ok !== want.pf)
          report_mismatch("prefetch_ok", 64'(out_bus.prefetch_ok), 64'(want.pf));
      end
    end
    if (rst_n && in_bus.valid && in_bus.ready)
      expected_results.push_back(predict_access(in_bus.access_pc, in_bus.access_address));
    in_took <= rst_n && in_bus.valid && in_bus.ready;
  end

  initial begin
    int i, k, phase;
    for (i = 0; i < N_ENT; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_pc[i] = '0;
      tbl_line[i] = '0;
      tbl_stride[i] = '0;
      tbl_conf[i] = CONF_NEW;
      tbl_age[i] = i % N_WAYS;
    end
    for (i = 0; i < POOL; i++) begin
      stream_pc[i] = pc_in_set(i % 5);
      stream_addr[i] = rand64();
      stream_step[i] = pick_step();
    end
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // climb to full confidence, saturate, miss at 3, then adopt a negative stride
    queue_access(64'd0, 64'd0);
    queue_access(64'd0, 64'h40);
    queue_access(64'd0, 64'h80);
    queue_access(64'd0, 64'hc0);
    queue_access(64'd0, 64'h100);
    queue_access(64'd0, 64'h1000);
    queue_access(64'd0, 64'h40);
    // all-ones fields and a wrapping stride
    queue_access('1, '1);
    queue_access('1, 64'd0);
    // same line repeatedly: zero stride is adopted and keeps missing
    queue_access(64'h100, 64'h2000);
    queue_access(64'h100, 64'h2000);
    queue_access(64'h100, 64'h2000);
    queue_access(64'h100, 64'h2040);
    // five tags into one set: eviction of the oldest, then LRU reshuffle
    for (k = 1; k <= 5; k++) queue_access({32'(k), 32'h1c}, 64'(k) << 6);
    queue_access({32'd1, 32'h1c}, 64'h80);
    queue_access({32'd3, 32'h1c}, 64'h100);
    add_stream_items(PHASE_ITEMS);

    for (phase = 1; phase < N_PHASES; phase++) begin
      wait_idle();
      cfg_wdata = PHASE_SHIFT[phase];
      cfg_we = 1'b1;
      @(negedge clk);
      cfg_we = 1'b0;
      blk_shift = PHASE_SHIFT[phase];
      no_gaps = (phase == 3);
      for (i = 0; i < POOL; i++) stream_step[i] = pick_step();
      add_stream_items(PHASE_ITEMS);
    end
    wait_idle();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
